@@ rtl/rau_pkg.sv @@
package rau_pkg;

  localparam int OperandWidth = 32;
  localparam int MagWidth = OperandWidth;
  localparam int ProdWidth = 2 * OperandWidth;
  localparam int ShiftWidth = $clog2(ProdWidth + 1);
  localparam int DivCountWidth = $clog2(ProdWidth + 1);

  typedef logic [ProdWidth-1:0] prod_t;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    GCD_IDLE,
    GCD_STRIP,
    GCD_RUN
  } gcd_state_t;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_GCD_DEN,
    SEQ_MUL_DEN,
    SEQ_WAIT_GCD_DEN,
    SEQ_DIV_LCM,
    SEQ_WAIT_DIV_LCM,
    SEQ_SCALE,
    SEQ_SCALE_B,
    SEQ_SUM,
    SEQ_GCD_RES,
    SEQ_WAIT_GCD_RES,
    SEQ_DIV_NUM,
    SEQ_WAIT_DIV_NUM,
    SEQ_DIV_DEN,
    SEQ_WAIT_DIV_DEN,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic neg;
    logic [MagWidth-1:0] mag;
  } operand_t;

  function automatic operand_t take_operand(input logic [31:0] raw);
    operand_t r;
    logic [OperandWidth-1:0] v;
    v = raw[OperandWidth-1:0];
    r.neg = v[OperandWidth-1];
    r.mag = r.neg ? MagWidth'(-v) : MagWidth'(v);
    return r;
  endfunction

endpackage

@@ rtl/rau_gcd.sv @@
module rau_gcd (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rau_pkg::ProdWidth-1:0]     x_in,
  input  logic [rau_pkg::ProdWidth-1:0]     y_in,
  output logic                              done,
  output logic [rau_pkg::ProdWidth-1:0]     g
);

  rau_pkg::gcd_state_t state, state_next;
  logic [rau_pkg::ProdWidth-1:0] x, y;
  logic [rau_pkg::ShiftWidth-1:0] shift;
  logic done_next;

  always_comb begin
    state_next = state;
    done_next = 1'b0;
    case (state)
      rau_pkg::GCD_IDLE: begin
        if (start) begin
          if (x_in == '0 || y_in == '0) begin
            done_next = 1'b1;
          end else begin
            state_next = rau_pkg::GCD_STRIP;
          end
        end
      end
      rau_pkg::GCD_STRIP: begin
        if ((x[0] | y[0]) && x[0]) state_next = rau_pkg::GCD_RUN;
      end
      rau_pkg::GCD_RUN: begin
        if (y == '0) begin
          state_next = rau_pkg::GCD_IDLE;
          done_next = 1'b1;
        end
      end
      default: state_next = rau_pkg::GCD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::GCD_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
    end
  end

  // one shift or one subtract per cycle
  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::GCD_IDLE: begin
        if (start) begin
          x <= x_in;
          y <= y_in;
          shift <= '0;
          if (x_in == '0) g <= y_in;
          else if (y_in == '0) g <= x_in;
        end
      end
      rau_pkg::GCD_STRIP: begin
        if (!(x[0] | y[0])) begin
          x <= x >> 1;
          y <= y >> 1;
          shift <= shift + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end
      end
      rau_pkg::GCD_RUN: begin
        if (y == '0) begin
          g <= x << shift;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= y;
          y <= x - y;
        end else begin
          y <= y - x;
        end
      end
      default: ;
    endcase
  end

  property p_done_pulse;
    @(posedge clk) disable iff (rst) done |=> !done || $past(start);
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("gcd done held");

  property p_x_odd;
    @(posedge clk) disable iff (rst) state == rau_pkg::GCD_RUN |-> x[0];
  endproperty
  a_x_odd: assert property (p_x_odd) else $error("gcd x even in run");

  property p_start_idle;
    @(posedge clk) disable iff (rst) start |-> state == rau_pkg::GCD_IDLE;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("gcd start while busy");

endmodule

@@ rtl/rau_div.sv @@
module rau_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rau_pkg::ProdWidth-1:0]     dividend,
  input  logic [rau_pkg::ProdWidth-1:0]     divisor,
  output logic                              done,
  output logic [rau_pkg::ProdWidth-1:0]     quotient
);

  logic busy;
  logic [rau_pkg::DivCountWidth-1:0] count;
  logic [rau_pkg::ProdWidth-1:0] rem, dsr;
  logic [rau_pkg::ProdWidth:0] trial;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, quotient[rau_pkg::ProdWidth-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= rau_pkg::DivCountWidth'(rau_pkg::ProdWidth);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == rau_pkg::DivCountWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[rau_pkg::ProdWidth]) begin
        rem <= trial[rau_pkg::ProdWidth-1:0];
        quotient <= {quotient[rau_pkg::ProdWidth-2:0], 1'b1};
      end else begin
        rem <= {rem[rau_pkg::ProdWidth-2:0], quotient[rau_pkg::ProdWidth-1]};
        quotient <= {quotient[rau_pkg::ProdWidth-2:0], 1'b0};
      end
    end
  end

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("div done idle");

  property p_no_start_busy;
    @(posedge clk) disable iff (rst) start |-> !busy;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy) else $error("div start while busy");

  property p_count_zero_idle;
    @(posedge clk) disable iff (rst) !busy |-> count == '0 || $past(start) == 1'b0;
  endproperty
  a_count_zero_idle: assert property (p_count_zero_idle) else $error("div count");

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// channel  | direction | handshake            | payload
// request  | in        | in_valid, in_stall   | kind, a_num, a_den, b_num, b_den
// result   | out       | out_valid, out_stall | res_num, res_den, status
// one request at a time; add and subtract run a binary gcd on the denominators,
// three divisions, then a gcd and two divisions for reduction; multiply and
// divide go straight to the reduction, and an overflowing sum finishes
// without it. the shared restoring divider (one bit a cycle) and the binary
// gcd unit (one shift or subtract a cycle) do the iterative work; the
// products are formed on a single 32x32 multiplier.
// zero denominator and divide by zero go straight to the result.
// rst is synchronous; a held result stalls the sequencer until taken.
module rational_arithmetic_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] res_num,
  output logic [63:0] res_den,
  output logic [1:0]  status
);

  rau_pkg::seq_state_t state, state_next;
  rau_pkg::operand_t an, ad, bn, bd;
  rau_pkg::kind_t op;
  logic gcd_start, gcd_done, div_start, div_done;
  rau_pkg::prod_t gcd_x, gcd_y, gcd_g, div_a, div_b, div_q;
  rau_pkg::prod_t lcm, rn_mag, rd_mag, g, ta_mag, tb_mag;
  logic rn_neg, rd_neg, ta_neg, tb_neg;
  rau_pkg::prod_t ua, ub, sum, mul_p;
  logic [rau_pkg::MagWidth-1:0] mul_a, mul_b;
  logic [1:0] div_step;
  logic accept, bad_den, div_zero, add_ovf;
  rau_pkg::status_t st;

  assign accept = in_valid && !in_stall;
  assign in_stall = state != rau_pkg::SEQ_IDLE;
  assign bad_den = ad.mag == '0 || bd.mag == '0;
  assign div_zero = op == rau_pkg::KIND_DIV && bn.mag == '0;

  rau_gcd u_gcd (
    .clk, .rst, .start(gcd_start), .x_in(gcd_x), .y_in(gcd_y),
    .done(gcd_done), .g(gcd_g)
  );

  rau_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  // one shared 32x32 multiplier
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::SEQ_IDLE: if (accept) state_next = rau_pkg::SEQ_GCD_DEN;
      rau_pkg::SEQ_GCD_DEN: begin
        if (bad_den || div_zero)
          state_next = rau_pkg::SEQ_DONE;
        else if (op == rau_pkg::KIND_MUL || op == rau_pkg::KIND_DIV)
          state_next = rau_pkg::SEQ_MUL_DEN;
        else state_next = rau_pkg::SEQ_WAIT_GCD_DEN;
      end
      rau_pkg::SEQ_MUL_DEN: state_next = rau_pkg::SEQ_GCD_RES;
      rau_pkg::SEQ_WAIT_GCD_DEN: if (gcd_done) state_next = rau_pkg::SEQ_DIV_LCM;
      rau_pkg::SEQ_DIV_LCM: state_next = rau_pkg::SEQ_WAIT_DIV_LCM;
      rau_pkg::SEQ_WAIT_DIV_LCM: begin
        if (div_done)
          state_next = div_step == 2'd2 ? rau_pkg::SEQ_SCALE : rau_pkg::SEQ_DIV_LCM;
      end
      rau_pkg::SEQ_SCALE: state_next = rau_pkg::SEQ_SCALE_B;
      rau_pkg::SEQ_SCALE_B: state_next = rau_pkg::SEQ_SUM;
      rau_pkg::SEQ_SUM: begin
        if (add_ovf) state_next = rau_pkg::SEQ_DONE;
        else state_next = rau_pkg::SEQ_GCD_RES;
      end
      rau_pkg::SEQ_GCD_RES: state_next = rau_pkg::SEQ_WAIT_GCD_RES;
      rau_pkg::SEQ_WAIT_GCD_RES: if (gcd_done) state_next = rau_pkg::SEQ_DIV_NUM;
      rau_pkg::SEQ_DIV_NUM: state_next = rau_pkg::SEQ_WAIT_DIV_NUM;
      rau_pkg::SEQ_WAIT_DIV_NUM: if (div_done) state_next = rau_pkg::SEQ_DIV_DEN;
      rau_pkg::SEQ_DIV_DEN: state_next = rau_pkg::SEQ_WAIT_DIV_DEN;
      rau_pkg::SEQ_WAIT_DIV_DEN: if (div_done) state_next = rau_pkg::SEQ_DONE;
      rau_pkg::SEQ_DONE: if (!out_valid) state_next = rau_pkg::SEQ_IDLE;
      default: state_next = rau_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    gcd_start = 1'b0;
    gcd_x = rau_pkg::prod_t'(ad.mag);
    gcd_y = rau_pkg::prod_t'(bd.mag);
    div_start = 1'b0;
    div_a = lcm;
    div_b = rau_pkg::prod_t'(ad.mag);
    mul_a = an.mag;
    mul_b = bn.mag;
    case (state)
      rau_pkg::SEQ_GCD_DEN: begin
        gcd_start = (op == rau_pkg::KIND_ADD || op == rau_pkg::KIND_SUB) && !bad_den;
        if (op == rau_pkg::KIND_DIV) mul_b = bd.mag;
      end
      rau_pkg::SEQ_MUL_DEN: begin
        mul_a = ad.mag;
        mul_b = (op == rau_pkg::KIND_DIV) ? bn.mag : bd.mag;
      end
      rau_pkg::SEQ_DIV_LCM: begin
        div_start = 1'b1;
        case (div_step)
          2'd0: begin
            div_a = rau_pkg::prod_t'(ad.mag);
            div_b = g;
          end
          2'd1: div_b = rau_pkg::prod_t'(ad.mag);
          default: div_b = rau_pkg::prod_t'(bd.mag);
        endcase
      end
      rau_pkg::SEQ_WAIT_DIV_LCM: begin
        // |a_den| / gcd fits the operand width
        mul_a = div_q[rau_pkg::MagWidth-1:0];
        mul_b = bd.mag;
      end
      rau_pkg::SEQ_SCALE: begin
        mul_a = an.mag;
        mul_b = ta_mag[rau_pkg::MagWidth-1:0];
      end
      rau_pkg::SEQ_SCALE_B: begin
        mul_a = bn.mag;
        mul_b = tb_mag[rau_pkg::MagWidth-1:0];
      end
      rau_pkg::SEQ_GCD_RES: begin
        gcd_start = 1'b1;
        gcd_x = rn_mag;
        gcd_y = rd_mag;
      end
      rau_pkg::SEQ_DIV_NUM: begin
        div_start = 1'b1;
        div_a = rn_mag;
        div_b = g == '0 ? rau_pkg::prod_t'(1) : g;
      end
      rau_pkg::SEQ_DIV_DEN: begin
        div_start = 1'b1;
        div_a = rd_mag;
        div_b = g == '0 ? rau_pkg::prod_t'(1) : g;
      end
      default: ;
    endcase
  end

  assign ua = ta_neg ? -ta_mag : ta_mag;
  assign ub = tb_neg ? -tb_mag : tb_mag;
  assign sum = ua + ub;
  assign add_ovf = (ua[rau_pkg::ProdWidth-1] == ub[rau_pkg::ProdWidth-1])
                   && (sum[rau_pkg::ProdWidth-1] != ua[rau_pkg::ProdWidth-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::SEQ_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      else if (state == rau_pkg::SEQ_DONE && !out_valid) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::SEQ_IDLE: begin
        if (accept) begin
          op <= rau_pkg::kind_t'(kind);
          an <= rau_pkg::take_operand(a_num);
          ad <= rau_pkg::take_operand(a_den);
          bn <= rau_pkg::take_operand(b_num);
          bd <= rau_pkg::take_operand(b_den);
          div_step <= 2'd0;
        end
      end
      rau_pkg::SEQ_GCD_DEN: begin
        st <= rau_pkg::ST_OK;
        if (bad_den) st <= rau_pkg::ST_ZERO_DEN;
        else if (div_zero) st <= rau_pkg::ST_DIV_ZERO;
        rn_mag <= mul_p;
        if (op == rau_pkg::KIND_MUL) begin
          rn_neg <= an.neg ^ bn.neg;
          rd_neg <= ad.neg ^ bd.neg;
        end else begin
          rn_neg <= an.neg ^ bd.neg;
          rd_neg <= ad.neg ^ bn.neg;
        end
      end
      rau_pkg::SEQ_MUL_DEN: rd_mag <= mul_p;
      rau_pkg::SEQ_WAIT_GCD_DEN: if (gcd_done) g <= gcd_g;
      rau_pkg::SEQ_WAIT_DIV_LCM: begin
        if (div_done) begin
          div_step <= div_step + 2'd1;
          case (div_step)
            2'd0: lcm <= mul_p;
            2'd1: ta_mag <= div_q;
            default: tb_mag <= div_q;
          endcase
        end
      end
      rau_pkg::SEQ_SCALE: begin
        ta_mag <= mul_p;
        ta_neg <= an.neg ^ ad.neg;
        tb_neg <= bn.neg ^ bd.neg ^ (op == rau_pkg::KIND_SUB);
      end
      rau_pkg::SEQ_SCALE_B: tb_mag <= mul_p;
      rau_pkg::SEQ_SUM: begin
        if (add_ovf) begin
          st <= rau_pkg::ST_OVERFLOW;
          rn_mag <= '0;
          rd_mag <= '0;
        end else begin
          rn_neg <= sum[rau_pkg::ProdWidth-1];
          rn_mag <= sum[rau_pkg::ProdWidth-1] ? -sum : sum;
          rd_neg <= 1'b0;
          rd_mag <= lcm;
        end
      end
      rau_pkg::SEQ_WAIT_GCD_RES: if (gcd_done) g <= gcd_g;
      rau_pkg::SEQ_WAIT_DIV_NUM: if (div_done) rn_mag <= div_q;
      rau_pkg::SEQ_WAIT_DIV_DEN: if (div_done) rd_mag <= div_q;
      rau_pkg::SEQ_DONE: begin
        if (!out_valid) begin
          if (st == rau_pkg::ST_OK) begin
            res_num <= (rn_neg && rn_mag != '0) ? -rn_mag : rn_mag;
            res_den <= rd_neg ? -rd_mag : rd_mag;
          end else begin
            res_num <= '0;
            res_den <= '0;
          end
          status <= st;
        end
      end
      default: ;
    endcase
  end

  property p_stall_busy;
    @(posedge clk) disable iff (rst) state != rau_pkg::SEQ_IDLE |-> in_stall;
  endproperty
  a_stall_busy: assert property (p_stall_busy) else $error("request taken while busy");

  property p_out_from_done;
    @(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state) == rau_pkg::SEQ_DONE;
  endproperty
  a_out_from_done: assert property (p_out_from_done) else $error("result without done");

  property p_error_zero;
    @(posedge clk) disable iff (rst) out_valid && status != rau_pkg::ST_OK
      |-> res_num == '0 && res_den == '0;
  endproperty
  a_error_zero: assert property (p_error_zero) else $error("error result nonzero");

endmodule

@@ test/rational_arithmetic_unit_tb.sv @@
module rational_arithmetic_unit_tb;

  typedef struct {
    logic [63:0]       num;
    logic [63:0]       den;
    rau_pkg::status_t  st;
  } ratio_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = rau_pkg::KIND_ADD;
  logic [31:0] a_num = '0;
  logic [31:0] a_den = 32'd1;
  logic [31:0] b_num = '0;
  logic [31:0] b_den = 32'd1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] res_num;
  logic [63:0] res_den;
  logic [1:0]  status;

  ratio_t pending_ratios[$];
  int     err_count = 0;
  int     req_count = 0;
  int     res_count = 0;
  int     cycle_count = 0;
  bit     calm = 1'b0;
  int     kind_seen[4];
  int     status_seen[4];

  rational_arithmetic_unit u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 10_000_000) begin
      $display("timeout with %0d results outstanding", pending_ratios.size());
      $display("rational_arithmetic_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] bin_gcd(input logic [63:0] x, input logic [63:0] y);
    int sh;
    logic [63:0] t;
    sh = 0;
    if (x == 0) return y;
    if (y == 0) return x;
    while (((x | y) & 1) == 0) begin
      x >>= 1; y >>= 1; sh++;
    end
    while ((x & 1) == 0) x >>= 1;
    while (y != 0) begin
      while ((y & 1) == 0) y >>= 1;
      if (x > y) begin
        t = x; x = y; y = t;
      end
      y -= x;
    end
    return x << sh;
  endfunction

  function automatic logic [63:0] mag_of(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? -v : v;
    return {32'd0, m};
  endfunction

  function automatic logic [63:0] signed_of(input bit neg, input logic [63:0] m);
    return neg ? -m : m;
  endfunction

  function automatic ratio_t fraction_result(input logic [1:0] k, input logic [31:0] an,
                                             input logic [31:0] ad, input logic [31:0] bn,
                                             input logic [31:0] bd);
    ratio_t r;
    logic [63:0] g, lcm, ua, ub, total, nm, dm;
    bit nneg, dneg;
    r.num = '0;
    r.den = '0;
    r.st = rau_pkg::ST_OK;
    if (ad == 0 || bd == 0) begin
      r.st = rau_pkg::ST_ZERO_DEN;
      return r;
    end
    if (k == rau_pkg::KIND_DIV && bn == 0) begin
      r.st = rau_pkg::ST_DIV_ZERO;
      return r;
    end
    if (k == rau_pkg::KIND_ADD || k == rau_pkg::KIND_SUB) begin
      g = bin_gcd(mag_of(ad), mag_of(bd));
      lcm = (mag_of(ad) / g) * mag_of(bd);
      ua = signed_of(an[31] != ad[31], mag_of(an) * (lcm / mag_of(ad)));
      ub = signed_of((bn[31] != bd[31]) != (k == rau_pkg::KIND_SUB),
                     mag_of(bn) * (lcm / mag_of(bd)));
      total = ua + ub;
      if (ua[63] == ub[63] && total[63] != ua[63]) begin
        r.st = rau_pkg::ST_OVERFLOW;
        return r;
      end
      nneg = total[63];
      nm = nneg ? -total : total;
      dneg = 1'b0;
      dm = lcm;
    end else if (k == rau_pkg::KIND_MUL) begin
      nneg = an[31] != bn[31]; nm = mag_of(an) * mag_of(bn);
      dneg = ad[31] != bd[31]; dm = mag_of(ad) * mag_of(bd);
    end else begin
      nneg = an[31] != bd[31]; nm = mag_of(an) * mag_of(bd);
      dneg = ad[31] != bn[31]; dm = mag_of(ad) * mag_of(bn);
    end
    if (nm == 0) nneg = 1'b0;
    g = bin_gcd(nm, dm);
    if (g == 0) g = 1;
    r.num = signed_of(nneg, nm / g);
    r.den = signed_of(dneg, dm / g);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  // result side: random stall and checking
  always @(posedge clk) begin
    ratio_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        res_count++;
        status_seen[status]++;
        if (pending_ratios.size() == 0) begin
          report_mismatch("unexpected result", res_num, 64'd0);
        end else begin
          w = pending_ratios.pop_front();
          if (status != w.st) report_mismatch("status", 64'(status), 64'(w.st));
          if (res_num != w.num) report_mismatch("res_num", res_num, w.num);
          if (res_den != w.den) report_mismatch("res_den", res_den, w.den);
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 18);
    end
  end

  task automatic send_request(input logic [1:0] k, input logic [31:0] an, input logic [31:0] ad,
                              input logic [31:0] bn, input logic [31:0] bd);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    pending_ratios.push_back(fraction_result(k, an, ad, bn, bd));
    kind_seen[k]++;
    req_count++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom_range(20);
      1: return -$urandom_range(20);
      2: return $urandom_range(1000) * (1 << $urandom_range(10));
      3: return {1'($urandom_range(1)), 31'($urandom_range(3))}
                ^ {1'b0, {31{$urandom_range(1) == 1}}};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] mn = 32'h8000_0000;
    logic [31:0] mx = 32'h7fff_ffff;
    for (int k = 0; k < 4; k++) begin
      send_request(2'(k), 32'd1, 32'd2, 32'd1, 32'd3);
      send_request(2'(k), mn, mn, mn, mn);
      send_request(2'(k), mx, mx, mn, 32'hffff_ffff);
      send_request(2'(k), 32'd0, 32'hffff_fffb, 32'd7, 32'd5);
    end
    send_request(rau_pkg::KIND_ADD, 32'd3, 32'd0, 32'd1, 32'd1);
    send_request(rau_pkg::KIND_MUL, 32'd3, 32'd4, 32'd1, 32'd0);
    send_request(rau_pkg::KIND_DIV, 32'd3, 32'd4, 32'd0, 32'd9);
    // huge numerators scaled by a large lcm; the sums still fit in 64 bits
    send_request(rau_pkg::KIND_ADD, mn, 32'd1, mn, mx);
    send_request(rau_pkg::KIND_SUB, mx, 32'd1, mn, mx);
    send_request(rau_pkg::KIND_SUB, 32'd5, 32'd7, 32'd5, 32'd7);
    send_request(rau_pkg::KIND_DIV, 32'hffff_fffe, 32'd6, 32'hffff_fffd, 32'hffff_fff7);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 2);
      send_request(2'($urandom_range(3)), pick_value(), pick_value(), pick_value(),
                   pick_value());
    end
    calm = 1'b0;
  endtask

  task automatic test_full_range(input int n);
    for (int i = 0; i < n; i++)
      send_request(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1100);
    test_full_range(280);
    in_valid <= 1'b0;
    while (pending_ratios.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("%0d requests, %0d results; kinds add/sub/mul/div %0d/%0d/%0d/%0d", req_count,
             res_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("status ok/zero den/div zero/overflow %0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3]);
    if (err_count == 0 && pending_ratios.size() == 0) begin
      $display("rational_arithmetic_unit_tb: done, clean");
    end else begin
      $display("rational_arithmetic_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
